### src/srtf_tick_scheduler_top_defines.svh
// Assertion macros shared by the scheduler top level.
`ifndef SRTF_TICK_SCHEDULER_TOP_DEFINES_SVH
`define SRTF_TICK_SCHEDULER_TOP_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent (clocked by i_clk).
`define SRTF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its antecedent (clocked by i_clk).
`define SRTF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/srtf_pkg.sv
// Shared types and codes of the shortest-remaining-time-first scheduler.
package srtf_pkg;

    localparam int SUM_BITS = 20;
    localparam int STATUS_W = 3;

    // Operation codes of an input item
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_LOADED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RAN      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_CALC,
        S_EMIT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic tick_start;
        logic scan;
        logic exec;
        logic calc;
        logic emit;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic scan_done;
    } t_stat;

endpackage

### src/srtf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write and read the array
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/srtf_ctrl.sv
// Controller state machine of the scheduler: sequences load, scan and update.
module srtf_ctrl
    import srtf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_operation,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    t_state r_state;
    t_state n_state;

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Decode next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_operation == OP_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.tick_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_CALC;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

### src/srtf_dpath.sv
// Datapath of the scheduler: job table, selection scan, time and totals.
module srtf_dpath
    import srtf_pkg::*;
#(
    parameter int MAX_JOBS   = 16,
    parameter int TIME_BITS  = 16,
    parameter int BURST_BITS = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_cmd                             i_cmd,
    input  logic [TIME_BITS-1:0]             i_arrival_time,
    input  logic [BURST_BITS-1:0]            i_burst_time,
    output t_stat                            o_stat,
    output logic                             o_result_strobe,
    output logic [STATUS_W-1:0]              o_status,
    output logic [$clog2(MAX_JOBS+1)-1:0]    o_job_number,
    output logic                             o_finished,
    output logic [TIME_BITS-1:0]             o_job_waiting,
    output logic [TIME_BITS-1:0]             o_job_turnaround,
    output logic [TIME_BITS-1:0]             o_time_now,
    output logic [SUM_BITS-1:0]              o_sum_waiting,
    output logic [SUM_BITS-1:0]              o_sum_turnaround,
    output logic [$clog2(MAX_JOBS+1)-1:0]    o_done_jobs
);

    localparam int CNT_W  = $clog2(MAX_JOBS + 1);
    localparam int IDX_W  = $clog2(MAX_JOBS);
    localparam int WORD_W = TIME_BITS + 2 * BURST_BITS;
    localparam int CMP_W  = (TIME_BITS > BURST_BITS) ? TIME_BITS : BURST_BITS;
    localparam int ADD_W  = ((TIME_BITS > SUM_BITS) ? TIME_BITS : SUM_BITS) + 1;
    localparam logic [SUM_BITS-1:0]  SUM_MAX  = {SUM_BITS{1'b1}};
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // Table occupancy, time and totals
    logic [CNT_W-1:0]      r_count;
    logic [TIME_BITS-1:0]  r_clock;
    logic [SUM_BITS-1:0]   r_wsum;
    logic [SUM_BITS-1:0]   r_tsum;
    logic [CNT_W-1:0]      r_done;
    logic                  r_strobe;

    // Scan state
    logic [CNT_W-1:0]      r_scan_idx;
    logic                  r_rd_valid;
    logic [IDX_W-1:0]      r_rd_idx;
    logic                  r_pending;
    logic                  r_found;
    logic [IDX_W-1:0]      r_pick;
    logic [TIME_BITS-1:0]  r_best_arr;
    logic [BURST_BITS-1:0] r_best_bur;
    logic [BURST_BITS-1:0] r_best_rem;

    // Result fields
    logic [STATUS_W-1:0]   r_status;
    logic [CNT_W-1:0]      r_job;
    logic                  r_fin;
    logic [TIME_BITS-1:0]  r_wait;
    logic [TIME_BITS-1:0]  r_turn;

    // RAM ports
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [WORD_W-1:0]     wr_data;
    logic                  rd_issue;
    logic [WORD_W-1:0]     rd_data;

    logic [TIME_BITS-1:0]  d_arr;
    logic [BURST_BITS-1:0] d_bur;
    logic [BURST_BITS-1:0] d_rem;
    logic                  better;
    logic                  load_reject;
    logic [TIME_BITS-1:0]  clock_inc;
    logic [BURST_BITS-1:0] new_rem;
    logic [CMP_W-1:0]      turn_ext;
    logic [CMP_W-1:0]      bur_ext;
    logic [ADD_W-1:0]      wsum_add;
    logic [ADD_W-1:0]      tsum_add;

    srtf_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MAX_JOBS)
    ) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_issue),
        .i_rd_addr(r_scan_idx[IDX_W-1:0]),
        .o_rd_data(rd_data)
    );

    // Split the table word
    assign d_arr = rd_data[WORD_W-1 -: TIME_BITS];
    assign d_bur = rd_data[2*BURST_BITS-1 -: BURST_BITS];
    assign d_rem = rd_data[BURST_BITS-1:0];

    // Select the table write: a new job on load, the decremented entry on run
    assign load_reject = (i_burst_time == '0) || (r_count == CNT_W'(MAX_JOBS));
    assign new_rem     = r_best_rem - BURST_BITS'(1);
    always_comb begin
        if (i_cmd.exec) begin
            wr_en   = r_pending && r_found;
            wr_addr = r_pick;
            wr_data = {r_best_arr, r_best_bur, new_rem};
        end else begin
            wr_en   = i_cmd.load && !load_reject;
            wr_addr = r_count[IDX_W-1:0];
            wr_data = {i_arrival_time, i_burst_time, i_burst_time};
        end
    end

    // Issue one table read per scan cycle
    assign rd_issue        = i_cmd.scan && (r_scan_idx != r_count);
    assign o_stat.scan_done = (r_scan_idx == r_count) && !r_rd_valid;

    // Rank the entry just read against the best so far
    assign better = !r_found ||
                    (d_rem < r_best_rem) ||
                    ((d_rem == r_best_rem) &&
                     ((d_arr < r_best_arr) ||
                      ((d_arr == r_best_arr) && (d_bur < r_best_bur))));

    // Time plus one, held at its ceiling
    assign clock_inc = (r_clock == TIME_MAX) ? r_clock : r_clock + TIME_BITS'(1);

    // Operands of the waiting-time compare
    assign turn_ext = CMP_W'(r_turn);
    assign bur_ext  = CMP_W'(r_best_bur);

    // Total updates before saturation
    assign wsum_add = ADD_W'(r_wsum) + ADD_W'(r_wait);
    assign tsum_add = ADD_W'(r_tsum) + ADD_W'(r_turn);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_clock    <= '0;
            r_wsum     <= '0;
            r_tsum     <= '0;
            r_done     <= '0;
            r_strobe   <= 1'b0;
            r_scan_idx <= '0;
            r_rd_valid <= 1'b0;
            r_pending  <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            r_strobe <= i_cmd.load || i_cmd.emit;
            if (i_cmd.load && !load_reject) begin
                r_count <= r_count + CNT_W'(1);
            end
            // Clear scan state at the start of a tick
            if (i_cmd.tick_start) begin
                r_scan_idx <= '0;
                r_rd_valid <= 1'b0;
                r_pending  <= 1'b0;
                r_found    <= 1'b0;
            end
            // Advance the scan and track the pick
            if (i_cmd.scan) begin
                r_rd_valid <= rd_issue;
                if (rd_issue) begin
                    r_scan_idx <= r_scan_idx + CNT_W'(1);
                end
                if (r_rd_valid && (d_rem != '0)) begin
                    r_pending <= 1'b1;
                    if ((d_arr <= r_clock) && better) begin
                        r_found <= 1'b1;
                    end
                end
            end
            // Advance time when anything is pending
            if (i_cmd.exec && r_pending) begin
                r_clock <= clock_inc;
            end
            // Add a completed job to the totals
            if (i_cmd.emit && r_fin) begin
                r_wsum <= (wsum_add > ADD_W'(SUM_MAX)) ? SUM_MAX : wsum_add[SUM_BITS-1:0];
                r_tsum <= (tsum_add > ADD_W'(SUM_MAX)) ? SUM_MAX : tsum_add[SUM_BITS-1:0];
                r_done <= r_done + CNT_W'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_rd_idx <= r_scan_idx[IDX_W-1:0];
            if (r_rd_valid && (d_rem != '0) && (d_arr <= r_clock) && better) begin
                r_pick     <= r_rd_idx;
                r_best_arr <= d_arr;
                r_best_bur <= d_bur;
                r_best_rem <= d_rem;
            end
        end
        // Load result
        if (i_cmd.load) begin
            r_status <= load_reject ? ST_REJECTED : ST_LOADED;
            r_job    <= load_reject ? '0 : r_count + CNT_W'(1);
            r_fin    <= 1'b0;
            r_wait   <= '0;
            r_turn   <= '0;
        end
        // Tick result: status, job and turnaround
        if (i_cmd.exec) begin
            r_fin  <= 1'b0;
            r_turn <= '0;
            r_job  <= '0;
            if (!r_pending) begin
                r_status <= ST_NONE;
            end else if (!r_found) begin
                r_status <= ST_IDLE;
            end else begin
                r_status <= ST_RAN;
                r_job    <= CNT_W'(r_pick) + CNT_W'(1);
                if (new_rem == '0) begin
                    r_fin  <= 1'b1;
                    r_turn <= clock_inc - r_best_arr;
                end
            end
        end
        // Waiting time, clamped at zero
        if (i_cmd.calc) begin
            r_wait <= (r_fin && (turn_ext > bur_ext)) ?
                      TIME_BITS'(turn_ext - bur_ext) : '0;
        end
    end

    assign o_result_strobe  = r_strobe;
    assign o_status         = r_status;
    assign o_job_number     = r_job;
    assign o_finished       = r_fin;
    assign o_job_waiting    = r_wait;
    assign o_job_turnaround = r_turn;
    assign o_time_now       = r_clock;
    assign o_sum_waiting    = r_wsum;
    assign o_sum_turnaround = r_tsum;
    assign o_done_jobs      = r_done;

endmodule

### src/srtf_tick_scheduler_top.sv
// Load: busy stays low; result strobe in the next cycle; a new item may start then.
// Tick: table RAM read one entry per cycle; busy holds through the scan, execute,
// calculate and emit states, and the next item is taken once busy is low again.
// The result strobes in the first cycle busy is low; no stalls.
// Reset (synchronous) clears time, totals, counts and the strobe; table contents
// are undefined until loaded and get no clearing pass.
`include "srtf_tick_scheduler_top_defines.svh"

module srtf_tick_scheduler_top
    import srtf_pkg::*;
#(
    parameter int MAX_JOBS   = 16,
    parameter int TIME_BITS  = 16,
    parameter int BURST_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_operation,
    input  logic [TIME_BITS-1:0]          i_arrival_time,
    input  logic [BURST_BITS-1:0]         i_burst_time,
    output logic                          o_result_strobe,
    output logic [STATUS_W-1:0]           o_status,
    output logic [$clog2(MAX_JOBS+1)-1:0] o_job_number,
    output logic                          o_finished,
    output logic [TIME_BITS-1:0]          o_job_waiting,
    output logic [TIME_BITS-1:0]          o_job_turnaround,
    output logic [TIME_BITS-1:0]          o_time_now,
    output logic [SUM_BITS-1:0]           o_sum_waiting,
    output logic [SUM_BITS-1:0]           o_sum_turnaround,
    output logic [$clog2(MAX_JOBS+1)-1:0] o_done_jobs
);

    t_cmd  cmd;
    t_stat stat;
    logic  load_xfer;
    logic  tick_xfer;
    logic  fin_strobe;
    logic  ran_job;

    srtf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_operation(i_operation),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    srtf_dpath #(
        .MAX_JOBS  (MAX_JOBS),
        .TIME_BITS (TIME_BITS),
        .BURST_BITS(BURST_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_arrival_time  (i_arrival_time),
        .i_burst_time    (i_burst_time),
        .o_stat          (stat),
        .o_result_strobe (o_result_strobe),
        .o_status        (o_status),
        .o_job_number    (o_job_number),
        .o_finished      (o_finished),
        .o_job_waiting   (o_job_waiting),
        .o_job_turnaround(o_job_turnaround),
        .o_time_now      (o_time_now),
        .o_sum_waiting   (o_sum_waiting),
        .o_sum_turnaround(o_sum_turnaround),
        .o_done_jobs     (o_done_jobs)
    );

    // Decode transfers and result conditions for the checks
    assign load_xfer  = start && !busy && (i_operation == OP_LOAD);
    assign tick_xfer  = start && !busy && (i_operation == OP_TICK);
    assign fin_strobe = o_result_strobe && o_finished;
    assign ran_job    = (o_status == ST_RAN) && (o_job_number != '0);

    // Check result timing and consistency
    `SRTF_ASSERT_NEXT(a_load_result, load_xfer, o_result_strobe, "load transfer without result")
    `SRTF_ASSERT_NEXT(a_tick_busy, tick_xfer, busy, "tick transfer did not raise busy")
    `SRTF_ASSERT_NOW(a_strobe_idle, o_result_strobe, !busy, "result strobe while busy")
    `SRTF_ASSERT_NOW(a_fin_ran, fin_strobe, ran_job, "finished without a job run")

endmodule
